// ===== src/gzhp_pkg.sv =====
// ----------------------------------------------------------------------------
// gzhp_pkg: shared types and constants for the gzip header parser
// Holds the phase encoding, status codes, flag bits and the item structs
// that travel between the input stage, the parser and the output stage.
// ----------------------------------------------------------------------------
package gzhp_pkg;

    // Magic and method bytes of a gzip member header
    localparam logic [7:0] MAGIC0_BYTE = 8'h1f;
    localparam logic [7:0] MAGIC1_BYTE = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'd8;

    // Byte counts loaded into the down counter
    localparam logic [15:0] MTIME_BYTES = 16'd4;
    localparam logic [15:0] HCRC_BYTES = 16'd2;

    // Flag bit positions in the FLG byte
    localparam int FL_FHCRC_BIT = 1;
    localparam int FL_FEXTRA_BIT = 2;
    localparam int FL_FNAME_BIT = 3;
    localparam int FL_FCOMMENT_BIT = 4;

    // Header parsing phase
    typedef enum logic [3:0] {
        PH_MAGIC0 = 4'd0,
        PH_MAGIC1 = 4'd1,
        PH_METHOD = 4'd2,
        PH_FLAGS = 4'd3,
        PH_MTIME = 4'd4,
        PH_XFL = 4'd5,
        PH_OS = 4'd6,
        PH_XLEN_LO = 4'd7,
        PH_XLEN_HI = 4'd8,
        PH_EXTRA = 4'd9,
        PH_STRINGS = 4'd10,
        PH_HCRC = 4'd11,
        PH_DATA = 4'd12
    } phase_t;

    // Latched status
    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_BAD_MAGIC = 2'd1,
        ST_BAD_METHOD = 2'd2,
        ST_TRUNCATED = 2'd3
    } status_t;

    // One input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic end_mark;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic payload_valid;
        logic [7:0] payload_byte;
        logic header_done;
        logic [1:0] status;
        logic [7:0] header_flags;
        logic [31:0] mod_time;
        logic [7:0] os_code;
    } result_t;

endpackage

// ===== src/gzhp_in_stage.sv =====
// ----------------------------------------------------------------------------
// gzhp_in_stage: input register
// Captures one stream item per cycle while it is empty or its item is taken,
// and holds each item until the parser takes it.
module gzhp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gzhp_pkg::in_item_t in_item,
    output logic               item_valid,
    input  logic               item_take,
    output gzhp_pkg::in_item_t item
);
    import gzhp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign in_ready = !valid_reg || item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

// ===== src/gzhp_parse.sv =====
// ----------------------------------------------------------------------------
// gzhp_parse: header state machine
// Updates the phase, counters and captured header fields for one byte and
// forms the result item from the updated state.
// ----------------------------------------------------------------------------
module gzhp_parse (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  gzhp_pkg::in_item_t item,
    output gzhp_pkg::result_t  result
);
    import gzhp_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [15:0] remaining_reg;
    logic [15:0] remaining_next;
    logic [7:0]  flag_reg;
    logic [7:0]  flag_next;
    logic [31:0] time_reg;
    logic [31:0] time_next;
    logic [7:0]  os_reg;
    logic [7:0]  os_next;
    logic [1:0]  strings_reg;
    logic [1:0]  strings_next;
    status_t     error_reg;
    status_t     error_next;

    logic [1:0]  str_count;
    phase_t      crc_phase;
    phase_t      after_extra_phase;
    logic [15:0] remaining_dec;
    logic [15:0] xlen_full;
    logic [1:0]  strings_dec;
    logic        pv;
    logic [7:0]  pb;

    // Phase choices after the extra field and after the strings
    always_comb
    begin
        str_count = {1'b0, flag_reg[FL_FNAME_BIT]} + {1'b0, flag_reg[FL_FCOMMENT_BIT]};
        crc_phase = flag_reg[FL_FHCRC_BIT] ? PH_HCRC : PH_DATA;
        after_extra_phase = (str_count != 2'd0) ? PH_STRINGS : crc_phase;
        remaining_dec = remaining_reg - 16'd1;
        xlen_full = {item.data_byte, remaining_reg[7:0]};
        strings_dec = strings_reg - 2'd1;
    end

    // Next state for one accepted byte or end mark
    always_comb
    begin
        phase_next = phase_reg;
        remaining_next = remaining_reg;
        flag_next = flag_reg;
        time_next = time_reg;
        os_next = os_reg;
        strings_next = strings_reg;
        error_next = error_reg;
        pv = 1'b0;
        pb = 8'd0;
        if (step && error_reg == ST_OK)
        begin
            if (item.end_mark)
            begin
                if (phase_reg < PH_DATA)
                begin
                    error_next = ST_TRUNCATED;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_MAGIC0:
                    begin
                        if (item.data_byte == MAGIC0_BYTE)
                            phase_next = PH_MAGIC1;
                        else
                            error_next = ST_BAD_MAGIC;
                    end
                    PH_MAGIC1:
                    begin
                        if (item.data_byte == MAGIC1_BYTE)
                            phase_next = PH_METHOD;
                        else
                            error_next = ST_BAD_MAGIC;
                    end
                    PH_METHOD:
                    begin
                        if (item.data_byte == METHOD_DEFLATE)
                            phase_next = PH_FLAGS;
                        else
                            error_next = ST_BAD_METHOD;
                    end
                    PH_FLAGS:
                    begin
                        flag_next = item.data_byte;
                        remaining_next = MTIME_BYTES;
                        phase_next = PH_MTIME;
                    end
                    PH_MTIME:
                    begin
                        time_next = {item.data_byte, time_reg[31:8]};
                        remaining_next = remaining_dec;
                        if (remaining_dec == 16'd0)
                            phase_next = PH_XFL;
                    end
                    PH_XFL:
                    begin
                        phase_next = PH_OS;
                    end
                    PH_OS:
                    begin
                        os_next = item.data_byte;
                        if (flag_reg[FL_FEXTRA_BIT])
                        begin
                            phase_next = PH_XLEN_LO;
                        end
                        else
                        begin
                            strings_next = str_count;
                            phase_next = after_extra_phase;
                            if (after_extra_phase == PH_HCRC)
                                remaining_next = HCRC_BYTES;
                        end
                    end
                    PH_XLEN_LO:
                    begin
                        remaining_next = {8'd0, item.data_byte};
                        phase_next = PH_XLEN_HI;
                    end
                    PH_XLEN_HI:
                    begin
                        remaining_next = xlen_full;
                        if (xlen_full != 16'd0)
                        begin
                            phase_next = PH_EXTRA;
                        end
                        else
                        begin
                            strings_next = str_count;
                            phase_next = after_extra_phase;
                            if (after_extra_phase == PH_HCRC)
                                remaining_next = HCRC_BYTES;
                        end
                    end
                    PH_EXTRA:
                    begin
                        remaining_next = remaining_dec;
                        if (remaining_dec == 16'd0)
                        begin
                            strings_next = str_count;
                            phase_next = after_extra_phase;
                            if (after_extra_phase == PH_HCRC)
                                remaining_next = HCRC_BYTES;
                        end
                    end
                    PH_STRINGS:
                    begin
                        if (item.data_byte == 8'd0)
                        begin
                            strings_next = strings_dec;
                            if (strings_dec == 2'd0)
                            begin
                                phase_next = crc_phase;
                                if (crc_phase == PH_HCRC)
                                    remaining_next = HCRC_BYTES;
                            end
                        end
                    end
                    PH_HCRC:
                    begin
                        remaining_next = remaining_dec;
                        if (remaining_dec == 16'd0)
                            phase_next = PH_DATA;
                    end
                    default:
                    begin
                        pv = 1'b1;
                        pb = item.data_byte;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC0;
            remaining_reg <= 16'd0;
            flag_reg <= 8'd0;
            time_reg <= 32'd0;
            os_reg <= 8'd0;
            strings_reg <= 2'd0;
            error_reg <= ST_OK;
        end
        else
        begin
            phase_reg <= phase_next;
            remaining_reg <= remaining_next;
            flag_reg <= flag_next;
            time_reg <= time_next;
            os_reg <= os_next;
            strings_reg <= strings_next;
            error_reg <= error_next;
        end
    end

    // Result from the updated state
    always_comb
    begin
        result.payload_valid = pv;
        result.payload_byte = pb;
        result.header_done = (error_next == ST_OK) && (phase_next >= PH_DATA);
        result.status = error_next;
        result.header_flags = flag_next;
        result.mod_time = time_next;
        result.os_code = os_next;
    end

endmodule

// ===== src/gzhp_out_stage.sv =====
// ----------------------------------------------------------------------------
// gzhp_out_stage: result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module gzhp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  gzhp_pkg::result_t result_in,
    output logic              load_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output gzhp_pkg::result_t result_out
);
    import gzhp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Take a new result when empty or when the held one leaves
    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until replaced
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== src/gzip_header_parser.sv =====
// Path: a byte accepted into the input register is parsed on its way into
// the result register, from where its result item can be taken downstream.
// Throughput: one byte per cycle while downstream keeps taking results; the
// phase update for a byte is combinational between the two registers.
// Reset (rst_n low, asynchronous): both registers empty, phase back to the
// first magic byte, counters, captured fields and status cleared.
// ----------------------------------------------------------------------------
// gzip_header_parser: gzip member header stripper
// Checks magic and method, captures flags, modification time and OS byte,
// skips optional header parts and passes the bytes after the header through.
// ----------------------------------------------------------------------------
module gzip_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // end_mark
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [7:0] payload_byte, [8] header_done,
                                       // [10:9] status, [18:11] header_flags,
                                       // [50:19] mod_time, [58:51] os_code,
                                       // [63:59] zero
    output logic        m_axis_tuser   // payload_valid
);
    import gzhp_pkg::*;

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     load_ready;
    logic     step;
    result_t  result_in;
    result_t  result_out;

    assign in_item.data_byte = s_axis_tdata;
    assign in_item.end_mark = s_axis_tlast;

    // Move a byte from the input register into the result register
    assign step = item_valid && load_ready;

    gzhp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (step),
        .item       (item)
    );

    gzhp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result_in)
    );

    gzhp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result_in  (result_in),
        .load_ready (load_ready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result_out (result_out)
    );

    // Pack the result item
    assign m_axis_tdata = {5'd0, result_out.os_code, result_out.mod_time,
                           result_out.header_flags, result_out.status,
                           result_out.header_done, result_out.payload_byte};
    assign m_axis_tuser = result_out.payload_valid;

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for gzip_header_parser
// Feeds one gzip member (header plus payload) through the byte stream, or a
// header that breaks on magic, method or an early end, and checks every result
// item against a cycle-free model of the parser kept in this bench.
// ----------------------------------------------------------------------------
module tb;

    import gzhp_pkg::*;

    localparam int STREAM_ITEMS = 1450;
    localparam int IDLE_PCT = 23;
    localparam int QUIET_FROM = 150;
    localparam int QUIET_TO = 400;
    localparam int HOLD_AT = 100;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 6;
    localparam int SHOWN_ERRORS = 10;

    // Shape of the member sent in this run
    typedef enum int {
        RUN_CLEAN,
        RUN_BAD_MAGIC0,
        RUN_BAD_MAGIC1,
        RUN_BAD_METHOD,
        RUN_CUT_SHORT
    } run_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // end_mark
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [7:0] payload_byte, [8] header_done,
                                         // [10:9] status, [18:11] header_flags,
                                         // [50:19] mod_time, [58:51] os_code
    logic        m_axis_tuser;           // payload_valid

    in_item_t    byte_q[$];
    result_t     parsed_q[$];
    in_item_t    next_item;
    in_item_t    taken_item;
    result_t     want;
    result_t     seen;
    int          sent_cnt = 0;
    int          got_cnt = 0;
    int          mismatches = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          stall_cycles = 0;

    // Parser state mirrored by the bench
    phase_t      ph = PH_MAGIC0;
    logic [15:0] left_cnt = '0;
    logic [7:0]  flg_cap = '0;
    logic [31:0] time_cap = '0;
    logic [7:0]  os_cap = '0;
    logic [1:0]  strings_todo = '0;
    status_t     err_st = ST_OK;

    gzip_header_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Leave the optional parts: header CRC if flagged, else payload
    function automatic void go_hcrc_or_data();
        if (flg_cap[FL_FHCRC_BIT])
        begin
            ph = PH_HCRC;
            left_cnt = HCRC_BYTES;
        end
        else
            ph = PH_DATA;
    endfunction

    // Count the flagged strings and skip them, or move past them
    function automatic void go_strings();
        strings_todo = 2'(flg_cap[FL_FNAME_BIT]) + 2'(flg_cap[FL_FCOMMENT_BIT]);
        if (strings_todo != 2'd0)
            ph = PH_STRINGS;
        else
            go_hcrc_or_data();
    endfunction

    // Advance the mirrored parser by one item and return its result item
    function automatic result_t parse_item(in_item_t it);
        result_t r;
        r = '0;
        if (err_st == ST_OK)
        begin
            if (it.end_mark)
            begin
                if (ph < PH_DATA)
                    err_st = ST_TRUNCATED;
            end
            else
            begin
                case (ph)
                    PH_MAGIC0:
                        if (it.data_byte == MAGIC0_BYTE) ph = PH_MAGIC1;
                        else err_st = ST_BAD_MAGIC;
                    PH_MAGIC1:
                        if (it.data_byte == MAGIC1_BYTE) ph = PH_METHOD;
                        else err_st = ST_BAD_MAGIC;
                    PH_METHOD:
                        if (it.data_byte == METHOD_DEFLATE) ph = PH_FLAGS;
                        else err_st = ST_BAD_METHOD;
                    PH_FLAGS:
                    begin
                        flg_cap = it.data_byte;
                        left_cnt = MTIME_BYTES;
                        ph = PH_MTIME;
                    end
                    PH_MTIME:
                    begin
                        time_cap = {it.data_byte, time_cap[31:8]};
                        left_cnt = left_cnt - 16'd1;
                        if (left_cnt == 16'd0) ph = PH_XFL;
                    end
                    PH_XFL:
                        ph = PH_OS;
                    PH_OS:
                    begin
                        os_cap = it.data_byte;
                        if (flg_cap[FL_FEXTRA_BIT]) ph = PH_XLEN_LO;
                        else go_strings();
                    end
                    PH_XLEN_LO:
                    begin
                        left_cnt = {8'h00, it.data_byte};
                        ph = PH_XLEN_HI;
                    end
                    PH_XLEN_HI:
                    begin
                        left_cnt[15:8] = it.data_byte;
                        if (left_cnt != 16'd0) ph = PH_EXTRA;
                        else go_strings();
                    end
                    PH_EXTRA:
                    begin
                        left_cnt = left_cnt - 16'd1;
                        if (left_cnt == 16'd0) go_strings();
                    end
                    PH_STRINGS:
                        if (it.data_byte == 8'h00)
                        begin
                            strings_todo = strings_todo - 2'd1;
                            if (strings_todo == 2'd0) go_hcrc_or_data();
                        end
                    PH_HCRC:
                    begin
                        left_cnt = left_cnt - 16'd1;
                        if (left_cnt == 16'd0) ph = PH_DATA;
                    end
                    default:
                    begin
                        r.payload_valid = 1'b1;
                        r.payload_byte = it.data_byte;
                    end
                endcase
            end
        end
        r.header_done = (err_st == ST_OK) && (ph >= PH_DATA);
        r.status = err_st;
        r.header_flags = flg_cap;
        r.mod_time = time_cap;
        r.os_code = os_cap;
        return r;
    endfunction

    // Queue one item for the sender
    task automatic send(input logic [7:0] b, input logic last);
        in_item_t it;
        it.data_byte = b;
        it.end_mark = last;
        byte_q.push_back(it);
    endtask

    // Build the member, then wait for it to drain and report
    initial
    begin
        logic [7:0] hdr[$];
        logic [7:0] flg_v;
        logic [7:0] b;
        int         xlen;
        int         n;
        int         pick;
        run_kind_t  kind;

        // Header with random content; optional parts present most of the time
        flg_v = 8'($urandom_range(0, 255));
        flg_v[FL_FHCRC_BIT] = ($urandom_range(0, 3) != 0);
        flg_v[FL_FEXTRA_BIT] = ($urandom_range(0, 3) != 0);
        flg_v[FL_FNAME_BIT] = ($urandom_range(0, 3) != 0);
        flg_v[FL_FCOMMENT_BIT] = ($urandom_range(0, 3) != 0);
        hdr.push_back(MAGIC0_BYTE);
        hdr.push_back(MAGIC1_BYTE);
        hdr.push_back(METHOD_DEFLATE);
        hdr.push_back(flg_v);
        for (int i = 0; i < 6; i++)
            hdr.push_back(8'($urandom_range(0, 255)));
        if (flg_v[FL_FEXTRA_BIT])
        begin
            // mostly short extra fields, sometimes one past 255, sometimes empty
            pick = $urandom_range(0, 7);
            xlen = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(256, 300)
                                                 : $urandom_range(1, 12);
            hdr.push_back(8'(xlen));
            hdr.push_back(8'(xlen >> 8));
            for (int i = 0; i < xlen; i++)
                hdr.push_back(8'($urandom_range(0, 255)));
        end
        for (int s = 0; s < 2; s++)
        begin
            if ((s == 0) ? flg_v[FL_FNAME_BIT] : flg_v[FL_FCOMMENT_BIT])
            begin
                n = $urandom_range(0, 12);
                for (int i = 0; i < n; i++)
                    hdr.push_back(8'($urandom_range(1, 255)));
                hdr.push_back(8'h00);
            end
        end
        if (flg_v[FL_FHCRC_BIT])
        begin
            hdr.push_back(8'($urandom_range(0, 255)));
            hdr.push_back(8'($urandom_range(0, 255)));
        end

        // Most runs carry a clean member; the rest break the header
        pick = $urandom_range(0, 15);
        kind = (pick < 12) ? RUN_CLEAN : run_kind_t'(pick - 11);

        case (kind)
            RUN_CLEAN:
            begin
                foreach (hdr[i])
                    send(hdr[i], 1'b0);
                // payload extremes, an end in payload and bytes after it
                send(8'h00, 1'b0);
                send(8'hff, 1'b0);
                send(8'h5a, 1'b1);
                send(8'h01, 1'b0);
                send(8'h80, 1'b0);
                send(8'h7f, 1'b0);
                while (byte_q.size() < STREAM_ITEMS)
                    send(8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
            end
            RUN_BAD_MAGIC0:
            begin
                b = 8'($urandom_range(0, 255));
                send((b == MAGIC0_BYTE) ? ~b : b, 1'b0);
            end
            RUN_BAD_MAGIC1:
            begin
                b = 8'($urandom_range(0, 255));
                send(MAGIC0_BYTE, 1'b0);
                send((b == MAGIC1_BYTE) ? ~b : b, 1'b0);
            end
            RUN_BAD_METHOD:
            begin
                b = 8'($urandom_range(0, 255));
                send(MAGIC0_BYTE, 1'b0);
                send(MAGIC1_BYTE, 1'b0);
                send((b == METHOD_DEFLATE) ? ~b : b, 1'b0);
            end
            default:
            begin
                // end anywhere in the header, also before the first byte
                n = $urandom_range(0, hdr.size() - 1);
                for (int i = 0; i < n; i++)
                    send(hdr[i], 1'b0);
                send(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        if (kind != RUN_CLEAN)
        begin
            // the latched error must swallow all of these
            while (byte_q.size() < STREAM_ITEMS)
                send(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go in and every result to come back
        do
            @(negedge clk);
        while (byte_q.size() != 0 || s_axis_tvalid || parsed_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("[gzip_header_parser] OK");
        else
            $display("[gzip_header_parser] ERROR");
        $finish;
    end

    // Sender: predict on each accepted item, then offer the next one or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken_item.data_byte = s_axis_tdata;
                taken_item.end_mark = s_axis_tlast;
                parsed_q.push_back(parse_item(taken_item));
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (byte_q.size() != 0 &&
                    ((sent_cnt >= QUIET_FROM && sent_cnt < QUIET_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_item = byte_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= next_item.data_byte;
                    s_axis_tlast <= next_item.end_mark;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Hold the receiver off once for a long stretch so the parser backs up
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && got_cnt >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: compare each accepted result item with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_cnt <= got_cnt + 1;
                seen.payload_valid = m_axis_tuser;
                seen.payload_byte = m_axis_tdata[7:0];
                seen.header_done = m_axis_tdata[8];
                seen.status = m_axis_tdata[10:9];
                seen.header_flags = m_axis_tdata[18:11];
                seen.mod_time = m_axis_tdata[50:19];
                seen.os_code = m_axis_tdata[58:51];
                if (parsed_q.size() == 0)
                begin
                    if (mismatches < SHOWN_ERRORS)
                        $display("unexpected result item %0d: tdata=%016h tuser=%0d",
                                 got_cnt, m_axis_tdata, m_axis_tuser);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = parsed_q.pop_front();
                    if (seen !== want)
                    begin
                        if (mismatches < SHOWN_ERRORS)
                        begin
                            $display("%0d exp pv=%0d pb=%h hd=%0d st=%0d fl=%h mt=%h os=%h",
                                     got_cnt, want.payload_valid, want.payload_byte,
                                     want.header_done, want.status, want.header_flags,
                                     want.mod_time, want.os_code);
                            $display("%0d got pv=%0d pb=%h hd=%0d st=%0d fl=%h mt=%h os=%h",
                                     got_cnt, seen.payload_valid, seen.payload_byte,
                                     seen.header_done, seen.status, seen.header_flags,
                                     seen.mod_time, seen.os_code);
                        end
                        mismatches <= mismatches + 1;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) &&
                             ((got_cnt >= QUIET_FROM && got_cnt < QUIET_TO) ||
                              $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if neither side moves an item for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[gzip_header_parser] ERROR");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

// ===== gzip_header_parser.f =====
src/gzhp_pkg.sv
src/gzhp_in_stage.sv
src/gzhp_parse.sv
src/gzhp_out_stage.sv
src/gzip_header_parser.sv
sim/tb.sv
